/* src/polyline_edge_band_hit_test_assert.svh */
// Assertion macros for the polyline edge band hit test.
`ifndef POLYLINE_EDGE_BAND_HIT_TEST_ASSERT_SVH
`define POLYLINE_EDGE_BAND_HIT_TEST_ASSERT_SVH
`ifndef SYNTHESIS
`define PEBHT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PEBHT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEBHT_ASSERT_IMP(label, ante, cons, msg)
`define PEBHT_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* src/pebht_pkg.sv */
// Types and constants shared by the polyline edge band hit test modules.
`default_nettype none
package pebht_pkg;

	localparam int COORD_W    = 20;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int DOT_W      = PROD_W + 1;
	localparam int RND_W      = DIFF_W + 1;
	localparam int DX_W       = DIFF_W + 2;
	localparam int SQ_W       = 2 * DX_W;
	localparam int DIST_W     = 41;
	localparam int SW_W       = 16;
	localparam int EM_W       = 12;
	localparam int GS_W       = 12;
	localparam int OUTER_W    = SW_W + 1;
	localparam int INNER_W    = OUTER_W + 1;
	localparam int BSQ_W      = 2 * OUTER_W;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W  = ((6 * COORD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((1 + DIST_W + 7) / 8) * 8;

	localparam logic [CFG_ADDR_W-1:0] CFG_STROKE_WIDTH = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_MARGIN  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_GRIP_SIZE    = 2'd2;

	localparam logic [SW_W-1:0] STROKE_WIDTH_RST = 16'd16;
	localparam logic [EM_W-1:0] EDGE_MARGIN_RST  = 12'd16;
	localparam logic [GS_W-1:0] GRIP_SIZE_RST    = 12'd160;
	localparam logic [DIST_W-1:0] DIST_MAX       = {DIST_W{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_SUM,
		ST_DIV,
		ST_TSEL,
		ST_MUL2,
		ST_RND,
		ST_SUB,
		ST_SQR,
		ST_DIST,
		ST_MIN,
		ST_BAND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic sum;
		logic div_step;
		logic tsel;
		logic mul2;
		logic rnd;
		logic sub;
		logic sqr;
		logic dist_sat;
		logic min;
		logic band;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

/* src/polyline_edge_band_hit_test.sv */
// Top level of the polyline edge band hit test.
`default_nettype none
`include "polyline_edge_band_hit_test_assert.svh"
// Each input word is one segment of a polyline plus the query point; tlast marks the
// polyline's final segment, after which one result word gives the smallest squared
// distance (saturating, in squared coordinate LSBs) and the edge band hit flag.
// A segment is worked through before the next word can be taken; a final segment also
// passes the band and emit states. The restoring divider that forms the projection
// parameter t, one quotient bit per cycle, runs between the sum and the t select.
// The result sits in an output register, so input is taken while it waits; a final
// segment stalls only while the result before it has still not been taken.
module polyline_edge_band_hit_test
	import pebht_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// query_x, query_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
	input  wire [IN_DATA_W-1:0]   s_tdata,
	input  wire                   s_tlast,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// hit, min_distance_sq, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  wire                   cfg_we,
	input  wire [CFG_ADDR_W-1:0]  cfg_addr,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	pebht_ctl #(
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	pebht_dp #(
		.T_FRAC_BITS(T_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_tdata),
		.in_last  (s_tlast),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata)
	);

	`PEBHT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "taken while busy")
	`PEBHT_ASSERT_IMP(a_emit_only_last, cmd.emit, sts.last, "emit without last segment")
	`PEBHT_ASSERT_IMP(a_sat_no_hit, m_tvalid && (m_tdata[DIST_W:1] == DIST_MAX), !m_tdata[0], "sat hit")

endmodule
`default_nettype wire

/* src/pebht_ctl.sv */
// Sequencer for the per-segment distance computation and result emit.
`default_nettype none
module pebht_ctl
	import pebht_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int CNT_W = $clog2(T_FRAC_BITS);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic div_last;

	assign div_last = (cnt_q == CNT_W'(T_FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SUM) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL1;
			end
			ST_MUL1: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV: begin
				if (div_last) state_d = ST_TSEL;
			end
			ST_TSEL: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_RND;
			ST_RND:  state_d = ST_SUB;
			ST_SUB:  state_d = ST_SQR;
			ST_SQR:  state_d = ST_DIST;
			ST_DIST: state_d = ST_MIN;
			ST_MIN:  state_d = sts.last ? ST_BAND : ST_IDLE;
			ST_BAND: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul1     = (state_q == ST_MUL1);
		cmd.sum      = (state_q == ST_SUM);
		cmd.div_step = (state_q == ST_DIV);
		cmd.tsel     = (state_q == ST_TSEL);
		cmd.mul2     = (state_q == ST_MUL2);
		cmd.rnd      = (state_q == ST_RND);
		cmd.sub      = (state_q == ST_SUB);
		cmd.sqr      = (state_q == ST_SQR);
		cmd.dist_sat = (state_q == ST_DIST);
		cmd.min      = (state_q == ST_MIN);
		cmd.band     = (state_q == ST_BAND);
		cmd.emit     = (state_q == ST_EMIT) && sts.out_free;
		in_ready     = (state_q == ST_IDLE);
	end

endmodule
`default_nettype wire

/* src/pebht_dp.sv */
// Datapath: differences, projection divider, distance, running minimum, band test.
`default_nettype none
module pebht_dp
	import pebht_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  wire [IN_DATA_W-1:0]   in_data,
	input  wire                   in_last,
	input  wire                   cfg_we,
	input  wire [CFG_ADDR_W-1:0]  cfg_addr,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	localparam int T_W  = T_FRAC_BITS + 1;
	localparam int PM_W = T_FRAC_BITS + 2 + DIFF_W;
	localparam logic signed [PM_W-1:0] HALF =
		{{(PM_W - T_FRAC_BITS){1'b0}}, 1'b1, {(T_FRAC_BITS - 1){1'b0}}};
	localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	logic [SW_W-1:0] stroke_width_q;
	logic [EM_W-1:0] edge_margin_q;
	logic [GS_W-1:0] grip_size_q;

	logic signed [COORD_W-1:0] qx, qy, sx, sy, ex, ey;
	logic signed [DIFF_W-1:0]  abx_q, aby_q, apx_q, apy_q;
	logic                      last_q;
	logic [OUTER_W-1:0]        outer_q;
	logic signed [INNER_W-1:0] inner_q;

	logic signed [PROD_W-1:0]  abx2_q, aby2_q, dotx_q, doty_q;
	logic [PROD_W-1:0]         ab2_sum;
	logic signed [DOT_W-1:0]   dot_sum;
	logic [PROD_W-1:0]         ab2_q, rem_q;
	logic signed [DOT_W-1:0]   dot_q;
	logic [PROD_W:0]           rem_sh, rem_sub;
	logic                      rem_ge;
	logic [T_FRAC_BITS-1:0]    quo_q;
	logic                      tzero_q, tone_q;
	logic [T_W-1:0]            t_q;

	logic signed [PM_W-1:0]    tx_q, ty_q, tx_r, ty_r;
	logic signed [RND_W-1:0]   rx_q, ry_q;
	logic signed [DX_W-1:0]    dx_q, dy_q;
	logic signed [SQ_W-1:0]    dx2_q, dy2_q;
	logic [SQ_W:0]             dsum;
	logic [DIST_W-1:0]         dist_q, running_min_q;

	logic [BSQ_W-1:0]          outer_sq_q, inner_sq_q;
	logic signed [2*INNER_W-1:0] inner_prod;
	logic                      inner_neg_q;
	logic [DIST_W+1:0]         m4;
	logic                      hit_d, hit_q;
	logic [DIST_W-1:0]         min_out_q;
	logic                      out_valid_q;

	assign {ey, ex, sy, sx, qy, qx} = in_data[6*COORD_W-1:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_width_q <= STROKE_WIDTH_RST;
			edge_margin_q  <= EDGE_MARGIN_RST;
			grip_size_q    <= GRIP_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_STROKE_WIDTH: stroke_width_q <= cfg_wdata[SW_W-1:0];
				CFG_EDGE_MARGIN:  edge_margin_q  <= cfg_wdata[EM_W-1:0];
				CFG_GRIP_SIZE:    grip_size_q    <= cfg_wdata[GS_W-1:0];
				default: ;
			endcase
		end
	end

	assign ab2_sum = PROD_W'($unsigned(abx2_q)) + PROD_W'($unsigned(aby2_q));
	assign dot_sum = DOT_W'(dotx_q) + DOT_W'(doty_q);
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, ab2_q};
	assign rem_ge  = (rem_sh >= {1'b0, ab2_q});
	assign tx_r    = (tx_q + HALF) >>> T_FRAC_BITS;
	assign ty_r    = (ty_q + HALF) >>> T_FRAC_BITS;
	assign dsum    = {1'b0, $unsigned(dx2_q)} + {1'b0, $unsigned(dy2_q)};
	assign inner_prod = inner_q * inner_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			abx_q   <= DIFF_W'(ex) - DIFF_W'(sx);
			aby_q   <= DIFF_W'(ey) - DIFF_W'(sy);
			apx_q   <= DIFF_W'(qx) - DIFF_W'(sx);
			apy_q   <= DIFF_W'(qy) - DIFF_W'(sy);
			last_q  <= in_last;
			outer_q <= OUTER_W'(stroke_width_q) + OUTER_W'({edge_margin_q, 1'b0});
			inner_q <= $signed({1'b0, OUTER_W'(stroke_width_q) + OUTER_W'({edge_margin_q, 1'b0})})
				- $signed(INNER_W'(grip_size_q));
		end
		if (cmd.mul1) begin
			abx2_q <= PROD_W'(abx_q) * PROD_W'(abx_q);
			aby2_q <= PROD_W'(aby_q) * PROD_W'(aby_q);
			dotx_q <= PROD_W'(apx_q) * PROD_W'(abx_q);
			doty_q <= PROD_W'(apy_q) * PROD_W'(aby_q);
		end
		if (cmd.sum) begin
			ab2_q <= ab2_sum;
			dot_q <= dot_sum;
			rem_q <= dot_sum[PROD_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q   <= rem_ge ? rem_sub[PROD_W-1:0] : rem_sh[PROD_W-1:0];
			quo_q   <= {quo_q[T_FRAC_BITS-2:0], rem_ge};
			tzero_q <= (ab2_q == '0) || dot_q[DOT_W-1] || (dot_q == '0);
			tone_q  <= ($signed({1'b0, ab2_q}) <= dot_q);
		end
		if (cmd.tsel) begin
			if (tzero_q) t_q <= '0;
			else if (tone_q) t_q <= T_ONE;
			else t_q <= {1'b0, quo_q};
		end
		if (cmd.mul2) begin
			tx_q <= PM_W'($signed({1'b0, t_q})) * PM_W'(abx_q);
			ty_q <= PM_W'($signed({1'b0, t_q})) * PM_W'(aby_q);
		end
		if (cmd.rnd) begin
			rx_q <= tx_r[RND_W-1:0];
			ry_q <= ty_r[RND_W-1:0];
		end
		if (cmd.sub) begin
			dx_q <= DX_W'(apx_q) - DX_W'(rx_q);
			dy_q <= DX_W'(apy_q) - DX_W'(ry_q);
		end
		if (cmd.sqr) begin
			dx2_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
			dy2_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
		end
		if (cmd.dist_sat) begin
			dist_q <= (dsum > (SQ_W + 1)'(DIST_MAX)) ? DIST_MAX : dsum[DIST_W-1:0];
		end
		if (cmd.band) begin
			outer_sq_q  <= BSQ_W'(outer_q) * BSQ_W'(outer_q);
			inner_sq_q  <= inner_prod[BSQ_W-1:0];
			inner_neg_q <= inner_q[INNER_W-1];
		end
		if (cmd.emit) begin
			hit_q     <= hit_d;
			min_out_q <= running_min_q;
		end
	end

	// band test on 4x the squared distance, in half-LSB units
	always_comb begin
		m4    = {running_min_q, 2'b00};
		hit_d = (m4 <= (DIST_W + 2)'(outer_sq_q))
			&& (inner_neg_q || !(m4 < (DIST_W + 2)'(inner_sq_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= DIST_MAX;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.emit) begin
				running_min_q <= DIST_MAX;
			end else if (cmd.min && (dist_q < running_min_q)) begin
				running_min_q <= dist_q;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.last     = last_q;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = OUT_DATA_W'({min_out_q, hit_q});

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Testbench for the polyline edge band hit test: stimulus, prediction and result checks.
`timescale 1ns / 1ps
module testbench
	import pebht_pkg::*;
();

	localparam int T_FRAC = 16;
	localparam longint T_ONE = 64'sd1 <<< T_FRAC;
	localparam longint T_HALF = 64'sd1 <<< (T_FRAC - 1);
	localparam longint DIST_CAP = (64'sd1 <<< DIST_W) - 1;
	localparam int COORD_MIN = -(1 <<< (COORD_W - 1));
	localparam int COORD_MAX = (1 <<< (COORD_W - 1)) - 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES = 8;
	localparam int WORDS_PER_PHASE = 85;

	typedef struct packed {
		logic [COORD_W-1:0] qx;
		logic [COORD_W-1:0] qy;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic               last_seg;
	} seg_word_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] min_sq;
	} band_result_t;

	typedef enum int {RX_FREE, RX_COIN, RX_SLOW} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// query_x, query_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// hit, min_distance_sq, zero fill
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic [SW_W-1:0]   cfg_stroke = STROKE_WIDTH_RST;
	logic [EM_W-1:0]   cfg_margin = EDGE_MARGIN_RST;
	logic [GS_W-1:0]   cfg_grip = GRIP_SIZE_RST;
	logic [DIST_W-1:0] running_min = DIST_MAX;
	band_result_t      pending_results[$];
	band_result_t      want;
	int                errors = 0;
	int                words_sent = 0;
	int                burst_left = 0;
	bit                steady = 1'b0;
	rx_mode_t          rx_mode = RX_FREE;
	int                rx_left = 0;
	int                stall_count = 0;

	polyline_edge_band_hit_test dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [DIST_W-1:0] segment_dist_sq(input seg_word_t w);
		longint px, py, ax, ay, bx, by, abx, aby, apx, apy, ab2, dot, t, dx, dy, sq;
		px = $signed(w.qx);
		py = $signed(w.qy);
		ax = $signed(w.sx);
		ay = $signed(w.sy);
		bx = $signed(w.ex);
		by = $signed(w.ey);
		abx = bx - ax;
		aby = by - ay;
		apx = px - ax;
		apy = py - ay;
		ab2 = abx * abx + aby * aby;
		dot = apx * abx + apy * aby;
		if (ab2 == 0 || dot <= 0) begin
			t = 0;
		end else if (dot >= ab2) begin
			t = T_ONE;
		end else begin
			t = (dot <<< T_FRAC) / ab2;
		end
		// offset rounded half up to coordinate LSBs
		dx = apx - ((t * abx + T_HALF) >>> T_FRAC);
		dy = apy - ((t * aby + T_HALF) >>> T_FRAC);
		sq = dx * dx + dy * dy;
		return (sq > DIST_CAP) ? DIST_MAX : sq[DIST_W-1:0];
	endfunction

	// bands in half-LSB units, distance scaled by 4 to match
	function automatic logic band_hit(input logic [DIST_W-1:0] m);
		longint outer2, inner2, m4;
		outer2 = longint'(cfg_stroke) + 2 * longint'(cfg_margin);
		inner2 = outer2 - longint'(cfg_grip);
		m4 = longint'(m) <<< 2;
		return (m4 <= outer2 * outer2) && !(inner2 >= 0 && m4 < inner2 * inner2);
	endfunction

	function automatic seg_word_t make_seg(input int qx, qy, sx, sy, ex, ey, input bit last_seg);
		seg_word_t w;
		w.qx = qx[COORD_W-1:0];
		w.qy = qy[COORD_W-1:0];
		w.sx = sx[COORD_W-1:0];
		w.sy = sy[COORD_W-1:0];
		w.ex = ex[COORD_W-1:0];
		w.ey = ey[COORD_W-1:0];
		w.last_seg = last_seg;
		return w;
	endfunction

	function automatic int near_coord(input int c, input int r);
		int v;
		v = c + int'($urandom_range(2 * r)) - r;
		if (v < COORD_MIN) begin
			v = COORD_MIN;
		end else if (v > COORD_MAX) begin
			v = COORD_MAX;
		end
		return v;
	endfunction

	function automatic int full_coord();
		logic [COORD_W-1:0] r;
		r = COORD_W'($urandom());
		return $signed(r);
	endfunction

	task automatic send_segment(input seg_word_t w);
		logic [DIST_W-1:0] d;
		int gap;
		band_result_t res;
		if (burst_left == 0) begin
			gap = (steady || $urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid = 1'b0;
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {w.ey, w.ex, w.sy, w.sx, w.qy, w.qx};
		s_tlast = w.last_seg;
		do @(posedge clk); while (!s_tready);
		d = segment_dist_sq(w);
		if (d < running_min) begin
			running_min = d;
		end
		if (w.last_seg) begin
			res.hit = band_hit(running_min);
			res.min_sq = running_min;
			pending_results = {pending_results, res};
			running_min = DIST_MAX;
		end
		words_sent++;
	endtask

	task automatic wait_for_results(input int extra);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		case (addr)
			CFG_STROKE_WIDTH: cfg_stroke = value;
			CFG_EDGE_MARGIN: cfg_margin = value[EM_W-1:0];
			CFG_GRIP_SIZE: cfg_grip = value[GS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input logic [CFG_DATA_W-1:0] sw, em, gs);
		wait_for_results(SETTLE_CYCLES);
		write_reg(CFG_STROKE_WIDTH, sw);
		write_reg(CFG_EDGE_MARGIN, em);
		write_reg(CFG_GRIP_SIZE, gs);
	endtask

	// single-segment polyline, query straight above the middle at distance d
	task automatic probe(input int d);
		send_segment(make_seg(0, d, -160, 0, 160, 0, 1'b1));
	endtask

	// reset bands have a negative inner edge, so only the outer test applies
	task automatic test_default_band();
		probe(24);
		probe(25);
	endtask

	task automatic test_segment_geometry();
		send_segment(make_seg(40, -8, 16, 16, 16, 16, 1'b1));
		send_segment(make_seg(-50, 30, 0, 0, 100, 0, 1'b1));
		send_segment(make_seg(150, 30, 0, 0, 100, 0, 1'b1));
		send_segment(make_seg(2, 5, 0, 0, 7, 3, 1'b1));
		send_segment(make_seg(-5, 1, 0, 0, -7, -3, 1'b1));
		send_segment(make_seg(0, 0, 100, 100, 50, 10, 1'b0));
		send_segment(make_seg(0, 0, 50, 10, -50, 10, 1'b0));
		send_segment(make_seg(0, 0, -50, 10, -100, 100, 1'b1));
		// the first segment is as far from the query as the coordinates allow
		send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			1'b0));
		send_segment(make_seg(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
			1'b1));
		send_segment(make_seg(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			1'b1));
	endtask

	task automatic test_band_limits();
		apply_config(32, 8, 16);
		write_reg(CFG_UNUSED, '1);
		probe(15);
		probe(16);
		probe(24);
		probe(25);
		apply_config(0, 0, 0);
		probe(0);
		probe(1);
		apply_config('1, '1, '1);
		probe(34814);
		probe(34815);
		probe(36862);
		probe(36863);
	endtask

	task automatic random_config(input int phase);
		logic [CFG_DATA_W-1:0] sw, em, gs;
		case (phase)
			0: begin
				sw = '0; em = '0; gs = '0;
			end
			1: begin
				sw = '1; em = '1; gs = '1;
			end
			2: begin
				sw = '0; em = '0; gs = '1;
			end
			default: begin
				if ($urandom_range(1)) begin
					sw = CFG_DATA_W'($urandom());
					em = CFG_DATA_W'($urandom());
					gs = CFG_DATA_W'($urandom());
				end else begin
					sw = CFG_DATA_W'($urandom_range(256));
					em = CFG_DATA_W'($urandom_range(64));
					gs = CFG_DATA_W'($urandom_range(512));
				end
			end
		endcase
		apply_config(sw, em, gs);
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
	endtask

	// mostly chained polylines around the band, some full range, some broken
	task automatic random_polyline();
		int n, k, kind, span, reach, cx, cy, qx, qy, px, py, nx, ny;
		n = ($urandom_range(3) == 0) ? 1 : $urandom_range(6, 2);
		kind = $urandom_range(99);
		reach = (int'(cfg_stroke) + 2 * int'(cfg_margin)) / 2 + 4;
		case ($urandom_range(3))
			0: span = 4;
			1: span = 64;
			2: span = 2048;
			default: span = reach;
		endcase
		cx = int'($urandom_range(800000)) - 400000;
		cy = int'($urandom_range(800000)) - 400000;
		qx = near_coord(cx, reach);
		qy = near_coord(cy, reach);
		px = near_coord(cx, span);
		py = near_coord(cy, span);
		if (kind >= 70 && kind < 85) begin
			qx = full_coord(); qy = full_coord(); px = full_coord(); py = full_coord();
		end
		for (k = 0; k < n; k++) begin
			if (kind >= 85) begin
				qx = near_coord(cx, reach); qy = near_coord(cy, reach);
				px = near_coord(cx, span); py = near_coord(cy, span);
			end
			if (kind >= 70 && kind < 85) begin
				nx = full_coord(); ny = full_coord();
			end else begin
				nx = near_coord(cx, span); ny = near_coord(cy, span);
			end
			if ($urandom_range(9) == 0) begin
				nx = px; ny = py;
			end
			send_segment(make_seg(qx, qy, px, py, nx, ny, k == n - 1));
			px = nx;
			py = ny;
		end
	endtask

	task automatic test_random_polylines();
		int phase, phase_start;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config(phase);
			steady = (phase == 4);
			phase_start = words_sent;
			while (words_sent - phase_start < WORDS_PER_PHASE) begin
				random_polyline();
				if (phase == 5 || $urandom_range(15) == 0) begin
					wait_for_results(0);
				end
			end
		end
		steady = 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(2));
			rx_left = $urandom_range(256, 32);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE: m_tready = 1'b1;
			RX_COIN: m_tready = 1'($urandom_range(1));
			default: m_tready = ($urandom_range(15) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected: hit %0b min_sq %0d",
					$time, m_tdata[0], m_tdata[DIST_W:1]);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.hit) begin
					errors++;
					$display("%0t: hit expected %0b got %0b", $time, want.hit, m_tdata[0]);
				end
				if (m_tdata[DIST_W:1] !== want.min_sq) begin
					errors++;
					$display("%0t: min_distance_sq expected %0d got %0d",
						$time, want.min_sq, m_tdata[DIST_W:1]);
				end
			end
		end
	end

	// no word moved on any port for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			stall_count <= 0;
		end else if (stall_count == WATCHDOG_LIMIT) begin
			$display("** polyline_edge_band_hit_test: FAILED **");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		test_default_band();
		test_segment_geometry();
		test_band_limits();
		test_random_polylines();
		wait_for_results(SETTLE_CYCLES);
		if (errors == 0) begin
			$display("** polyline_edge_band_hit_test: PASSED **");
		end else begin
			$display("** polyline_edge_band_hit_test: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+src
src/pebht_pkg.sv
src/pebht_ctl.sv
src/pebht_dp.sv
src/polyline_edge_band_hit_test.sv
bench/testbench.sv
